// File: rtl/moving_average_of_differences_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef MOVING_AVERAGE_OF_DIFFERENCES_UNIT_MACROS_SVH
`define MOVING_AVERAGE_OF_DIFFERENCES_UNIT_MACROS_SVH

// plain property, checked every edge outside reset
`define MAVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MAVD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MAVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mavd_pkg.sv
package mavd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int DIFF_W   = 25;
    localparam int MEAN_W   = 33;
    localparam int WIN_W    = 11;
    localparam int FRAC_W   = 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIV,
        ST_OUT,
        ST_RECALC
    } t_state;

endpackage

// File: rtl/mavd_channels.sv
// sample input channel
interface mavd_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mavd_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// mean result channel
interface mavd_mean_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mavd_pkg::MEAN_W-1:0]    mean_difference;

    modport source (output valid, output mean_difference, input ready);
    modport sink   (input valid, input mean_difference, output ready);
endinterface

// File: rtl/mavd_store.sv
module mavd_store #(
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(DEPTH)-1:0]            i_waddr,
    input  logic signed [mavd_pkg::DIFF_W-1:0]  i_wdata,
    input  logic [$clog2(DEPTH)-1:0]            i_raddr,
    output logic signed [mavd_pkg::DIFF_W-1:0]  o_rdata
);
    import mavd_pkg::*;

    logic signed [DIFF_W-1:0] mem [DEPTH];
    logic signed [DIFF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mavd_div.sv
module mavd_div #(
    parameter int NUM_W = 44
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [mavd_pkg::WIN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [NUM_W-1:0]            o_quot
);
    import mavd_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [WIN_W-1:0] r_rem;
    logic [WIN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIN_W:0]   rem_sh;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_quot[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits the divisor width
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? WIN_W'(rem_sh - {1'b0, r_den}) : WIN_W'(rem_sh);
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/moving_average_of_differences_unit.sv
// moving average of first differences
// i_sample (valid/ready): one signed 24-bit sample per beat. the difference
//   from the previous sample is written into a ring store of MAX_WINDOW
//   entries at the write position, which then wraps at the window length
// o_mean (valid/ready): one beat per sample, the mean of store entries
//   0 .. window-1 with 8 fraction bits, truncated toward zero
// i_cfg_we / i_cfg_wdata: window length, 1 .. MAX_WINDOW; other values are
//   dropped. a write rewinds the write position and rescans the window to
//   rebuild the running sum, with no sample taken during the rescan
// one sample at a time: a new sample is taken only after the previous one
//   has passed the bit-serial divider and gone to the result register
// reset: the store is swept to zero, one entry per cycle, and no sample
//   is taken during the sweep; window resets to 1
// a stalled receiver holds the result register; the next sample can be
//   taken and processed but its result waits until the register frees
`include "moving_average_of_differences_unit_macros.svh"

module moving_average_of_differences_unit #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mavd_sample_if.sink                   i_sample,
    mavd_mean_if.source                   o_mean,
    input  logic                          i_cfg_we,
    input  logic [mavd_pkg::WIN_W-1:0]    i_cfg_wdata
);
    import mavd_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int SUM_W = DIFF_W + $clog2(MAX_WINDOW) + 1;
    localparam int NUM_W = SUM_W + FRAC_W;

    t_state r_state, n_state;

    // control and datapath registers
    logic [WIN_W-1:0]         r_win;
    logic [AW-1:0]            r_pos;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic [AW-1:0]            r_clr;
    logic [WIN_W-1:0]         r_rc_cnt;
    logic                     r_rc_pend;
    logic                     r_out_valid;
    logic signed [MEAN_W-1:0] r_out_data;

    // fsm outputs
    logic                     in_ready;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DIFF_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic                     div_start;

    logic                     in_acc;
    logic                     cfg_ok;
    logic                     out_free;
    logic                     rc_done;
    logic                     clr_last;
    logic signed [DIFF_W-1:0] rdata;
    logic                     div_done;
    logic [NUM_W-1:0]         quot;
    logic [SUM_W-1:0]         sum_mag;
    logic [NUM_W-1:0]         res_full;

    assign cfg_ok   = i_cfg_we && (i_cfg_wdata != '0)
                      && (32'(i_cfg_wdata) <= 32'(MAX_WINDOW));
    assign in_acc   = i_sample.valid && in_ready;
    assign out_free = !r_out_valid || o_mean.ready;
    assign rc_done  = (r_rc_cnt == r_win) && !r_rc_pend;
    assign clr_last = (r_clr == AW'(MAX_WINDOW - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (cfg_ok) begin
                    n_state = ST_RECALC;
                end else if (in_acc) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_START;
            ST_START:  n_state = ST_DIV;
            ST_DIV:    if (div_done) n_state = ST_OUT;
            ST_OUT:    if (out_free) n_state = ST_IDLE;
            ST_RECALC: if (!cfg_ok && rc_done) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // fsm outputs: store port and divider start
    always_comb begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_diff;
        mem_raddr = r_pos;
        div_start = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            ST_IDLE:   in_ready = !i_cfg_we;
            ST_UPDATE: mem_we = 1'b1;
            ST_START:  div_start = 1'b1;
            ST_RECALC: mem_raddr = AW'(r_rc_cnt);
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign i_sample.ready = in_ready;

    // magnitude of the sum scaled by 256 goes to the divider
    assign sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign res_full = r_neg ? (~quot + 1'b1) : quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_win       <= WIN_W'(1);
            r_pos       <= '0;
            r_prev      <= '0;
            r_sum       <= '0;
            r_clr       <= '0;
            r_rc_cnt    <= '0;
            r_rc_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // result register loads when free, else clears on a taken beat
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_mean.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            // window write rewinds; rescan only once the store is valid
            if (cfg_ok) begin
                r_win <= i_cfg_wdata;
                r_pos <= '0;
            end else if (r_state == ST_UPDATE) begin
                r_pos <= (32'(r_pos) + 1 == 32'(r_win)) ? '0 : r_pos + 1'b1;
            end

            if (cfg_ok && (r_state == ST_IDLE || r_state == ST_RECALC)) begin
                r_sum     <= '0;
                r_rc_cnt  <= '0;
                r_rc_pend <= 1'b0;
            end else if (r_state == ST_RECALC) begin
                // read issued this cycle, data summed the next
                r_rc_pend <= (r_rc_cnt != r_win);
                if (r_rc_cnt != r_win) begin
                    r_rc_cnt <= r_rc_cnt + 1'b1;
                end
                if (r_rc_pend) begin
                    r_sum <= r_sum + SUM_W'(rdata);
                end
            end

            if (in_acc) begin
                r_prev <= i_sample.sample;
            end

            if (r_state == ST_UPDATE) begin
                // old entry read at the accept edge, replaced by the new diff
                r_sum <= r_sum + SUM_W'(r_diff) - SUM_W'(rdata);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_diff <= DIFF_W'(i_sample.sample) - DIFF_W'(r_prev);
        end
        if (r_state == ST_START) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= MEAN_W'(res_full);
        end
    end

    assign o_mean.valid           = r_out_valid;
    assign o_mean.mean_difference = r_out_data;

    mavd_store #(
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    mavd_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({sum_mag, FRAC_W'(0)}),
        .i_den   (r_win),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    `MAVD_ASSERT(a_pos_in_window, i_clk, i_rst_n, 32'(r_pos) < 32'(r_win),
        "write position beyond window")
    `MAVD_ASSERT(a_win_range, i_clk, i_rst_n,
        (r_win != '0) && (32'(r_win) <= 32'(MAX_WINDOW)), "window length out of range")
    `MAVD_ASSERT_NEXT(a_accept_update, i_clk, i_rst_n, in_acc, r_state == ST_UPDATE,
        "accepted sample did not reach update")
    `MAVD_ASSERT_IMPL(a_div_done_state, i_clk, i_rst_n, div_done, r_state == ST_DIV,
        "divider finished outside divide state")
    `MAVD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        (r_state == ST_OUT) && r_out_valid && !o_mean.ready, r_state == ST_OUT,
        "result dropped while output stalled")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

// tracks the window state of the block and holds the means still owed
class mean_scoreboard;
    localparam int STORE_DEPTH = 1024;

    logic signed [mavd_pkg::SAMPLE_W-1:0] prev_sample;
    int unsigned                          wr_pos;
    int unsigned                          win_len;
    longint                               diff_store [STORE_DEPTH];
    logic signed [mavd_pkg::MEAN_W-1:0]   owed_means [$];
    int                                   errors;

    function new();
        prev_sample = '0;
        wr_pos      = 0;
        win_len     = 1;
        errors      = 0;
        foreach (diff_store[i]) diff_store[i] = 0;
    endfunction

    // lengths outside 1 .. depth are dropped by the block
    function void write_window(logic [mavd_pkg::WIN_W-1:0] len);
        if (len >= 1 && len <= STORE_DEPTH) begin
            win_len = 32'(len);
            wr_pos  = 0;
        end
    endfunction

    function void note_sample(logic signed [mavd_pkg::SAMPLE_W-1:0] s);
        longint sum;
        longint mean;
        sum = 0;
        diff_store[wr_pos] = longint'(s) - longint'(prev_sample);
        wr_pos = (wr_pos + 1) % win_len;
        for (int i = 0; i < win_len; i++) sum += diff_store[i];
        mean = (sum * 256) / longint'(win_len);
        owed_means.push_back(mean[mavd_pkg::MEAN_W-1:0]);
        prev_sample = s;
    endfunction

    function void check_mean(logic signed [mavd_pkg::MEAN_W-1:0] got);
        logic signed [mavd_pkg::MEAN_W-1:0] want;
        if (owed_means.size() == 0) begin
            $display("%0t unexpected mean_difference: expected none, got %0d", $time, got);
            errors++;
        end else begin
            want = owed_means.pop_front();
            if (got !== want) begin
                $display("%0t mean_difference mismatch: expected %0d, got %0d",
                         $time, want, got);
                errors++;
            end
        end
    endfunction

    function void report_leftovers();
        foreach (owed_means[i]) begin
            $display("%0t missing mean_difference: expected %0d, got none",
                     $time, owed_means[i]);
            errors++;
        end
    endfunction
endclass

module testbench;
    import mavd_pkg::*;

    localparam int MAX_WINDOW = 1024;
    // settling margin after the last owed mean has come back
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PER_PHASE = 250;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [WIN_W-1:0]   i_cfg_wdata;

    mavd_sample_if sample_ch ();
    mavd_mean_if   mean_ch ();

    mean_scoreboard board = new();

    // percent of cycles in which the sender holds off / the receiver stalls
    int idle_pct;
    int stall_pct;
    // last sample handed to the block, used for small-step sequences
    logic signed [SAMPLE_W-1:0] last_sent;

    moving_average_of_differences_unit #(
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_ch),
        .o_mean      (mean_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver side: random stalls on the result channel
    always @(posedge i_clk) begin
        mean_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: every accepted beat and every register write goes to the
    // scoreboard; values are the ones present just before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) board.write_window(i_cfg_wdata);
            if (sample_ch.valid && sample_ch.ready) board.note_sample(sample_ch.sample);
            if (mean_ch.valid && mean_ch.ready) board.check_mean(mean_ch.mean_difference);
        end
    end

    // hand one sample to the block, with random hold-off before it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        last_sent = s;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    // stop sending until every owed mean has come back, then let the
    // divider run out; the last accepted beat is noted before the wait
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.owed_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // window write only while the block is idle; ready high marks the end
    // of the reset sweep or of the previous rescan
    task automatic set_window(input logic [WIN_W-1:0] len);
        drain();
        do @(posedge i_clk); while (!sample_ch.ready);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly short windows, now and then full depth, mid size or a
    // length the block has to drop
    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(9))
            0: return WIN_W'(MAX_WINDOW);
            1: return WIN_W'($urandom_range(MAX_WINDOW - 1, 17));
            2: return ($urandom_range(1) != 0) ? WIN_W'($urandom_range(2047, MAX_WINDOW + 1))
                                               : '0;
            default: return WIN_W'($urandom_range(16, 1));
        endcase
    endfunction

    // full-range values, small steps from the last sample, and the rails
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return SAMPLE_W'($urandom);
            4, 5, 6:    return last_sent + SAMPLE_W'($signed($urandom_range(512)) - 256);
            7:          return SAMPLE_MAX;
            8:          return SAMPLE_MIN;
            default:    return '0;
        endcase
    endfunction

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        mean_ch.ready    = 1'b0;
        last_sent        = '0;
        idle_pct         = 0;
        stall_pct        = 0;

        // reset once; the block then sweeps its store before taking samples
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // window of one: the mean is the difference itself, so the rails
        // give the largest positive and negative results
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        send_sample(SAMPLE_MIN);

        // lengths of zero or above the store depth must leave things alone
        set_window('0);
        set_window(WIN_W'(MAX_WINDOW + 1));
        set_window('1);
        send_sample(24'sd1000);
        send_sample(-24'sd1000);

        // full depth, odd sums so truncation toward zero shows
        set_window(WIN_W'(MAX_WINDOW));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(24'sd123);
        send_sample(-24'sd77);

        // shrink, wrap around, then grow so old entries come back in
        set_window(WIN_W'(3));
        send_sample(24'sd5);
        send_sample(-24'sd4);
        send_sample(24'sd9);
        send_sample(-24'sd2);
        set_window(WIN_W'(7));
        send_sample(24'sd11);
        send_sample(-24'sd13);
        send_sample(24'sd1);

        // random part in three idling profiles
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 32;
                    stall_pct = 86;
                end
                1: begin
                    idle_pct  = 86;
                    stall_pct = 32;
                end
                default: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 50 == 0) set_window(pick_window());
                else if (n == 125) drain();
                send_sample(pick_sample());
            end
        end

        drain();
        board.report_leftovers();
        if (board.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #8_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
